FILE: rtl/swv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swv_pkg: shared constants and types for the sliding window variance block
// Window geometry, datapath widths, divider shape and the words that pass
// between the front end, the variance pipeline, the queue and the back end.
// ----------------------------------------------------------------------------
package swv_pkg;

  localparam int unsigned HALF_WIDTH = 20;
  localparam int unsigned WIN_LEN    = 2 * HALF_WIDTH + 1;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned VAR_W    = 31;
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned SQ_W     = 38;
  localparam int unsigned SEEN_W   = $clog2(WIN_LEN + 1);
  localparam int unsigned FLUSH_W  = $clog2(HALF_WIDTH + 1);

  // magnitude of the running sum and the width of N*sumsq - sum^2
  localparam int unsigned MAG_W = SUM_W - 1;
  localparam int unsigned NUM_W = 2 * MAG_W;

  // constant divisor N*(N-1), restoring division a digit group per stage
  localparam int unsigned DIVISOR    = WIN_LEN * (WIN_LEN - 1);
  localparam int unsigned REM_W      = $clog2(DIVISOR);
  localparam int unsigned DIV_DIGITS = 8;
  localparam int unsigned DIV_STAGES = (NUM_W + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int unsigned DIV_BITS   = DIV_STAGES * DIV_DIGITS;

  // queue between the variance pipeline and the back end (power of two)
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic               regular;  // one result for the centre index
    logic               full;     // window complete, variance is real
    logic [FLUSH_W-1:0] flush_n;  // edge zeros to emit after it
  } swv_ctl_t;

  typedef struct packed {
    swv_ctl_t                 ctl;
    logic signed [SUM_W-1:0]  s1;
    logic        [SQ_W-1:0]   s2;
  } swv_job_t;

  typedef struct packed {
    swv_ctl_t           ctl;
    logic [VAR_W-1:0]   variance;
  } swv_work_t;

endpackage
`default_nettype wire

FILE: rtl/swv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swv_if: stream channels of the sliding window variance block
// Sample channel into the block and result channel out of it, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface swv_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [swv_pkg::SAMPLE_W-1:0] sample;
  logic                               final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface swv_out_if;
  logic                        valid;
  logic                        ready;
  logic [swv_pkg::VAR_W-1:0]   window_variance;
  logic                        edge_zero;
  logic                        trace_end;

  modport source (output valid, output window_variance, output edge_zero,
                  output trace_end, input ready);
  modport sink   (input valid, input window_variance, input edge_zero,
                  input trace_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/swv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swv_front: sample intake and window bookkeeping
// Keeps the sample delay line, running sum, sum of squares and sample count,
// and classifies each accepted word into a job for the variance pipeline.
// ----------------------------------------------------------------------------
module swv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  swv_in_if.sink            in_if,
  input  logic              adv_i,
  output logic              job_valid_o,
  output swv_pkg::swv_job_t job_o
);
  import swv_pkg::*;

  logic signed [SAMPLE_W-1:0]   win_q [WIN_LEN];
  logic signed [SUM_W-1:0]      sum_q, sum_d, sum_upd;
  logic        [SQ_W-1:0]       sq_q, sq_d, sq_upd;
  logic        [SEEN_W-1:0]     seen_q, seen_d, count;
  logic signed [2*SAMPLE_W-1:0] new_sq, old_sq;
  logic                         accept, full_before;
  logic                         job_valid_q;
  swv_job_t                     job_q, job_d;

  assign in_if.ready = adv_i;
  assign accept      = in_if.valid && adv_i;
  assign full_before = (seen_q == SEEN_W'(WIN_LEN));
  assign new_sq      = in_if.sample * in_if.sample;
  assign old_sq      = win_q[0] * win_q[0];

  always_comb begin
    count   = full_before ? seen_q : seen_q + 1'b1;
    sum_upd = sum_q + SUM_W'(in_if.sample);
    sq_upd  = sq_q + SQ_W'(unsigned'(new_sq));
    // oldest sample leaves only once the window is complete
    if (full_before) begin
      sum_upd = sum_upd - SUM_W'(win_q[0]);
      sq_upd  = sq_upd - SQ_W'(unsigned'(old_sq));
    end

    job_d.ctl.regular = (count >= SEEN_W'(HALF_WIDTH + 1));
    job_d.ctl.full    = (count == SEEN_W'(WIN_LEN));
    job_d.ctl.flush_n = '0;
    if (in_if.final_sample) begin
      job_d.ctl.flush_n = (count < SEEN_W'(HALF_WIDTH)) ? FLUSH_W'(count)
                                                        : FLUSH_W'(HALF_WIDTH);
    end
    job_d.s1 = sum_upd;
    job_d.s2 = sq_upd;

    // last sample of a trace starts a fresh trace
    if (in_if.final_sample) begin
      sum_d  = '0;
      sq_d   = '0;
      seen_d = '0;
    end else begin
      sum_d  = sum_upd;
      sq_d   = sq_upd;
      seen_d = count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sq_q        <= '0;
      seen_q      <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        sum_q  <= sum_d;
        sq_q   <= sq_d;
        seen_q <= seen_d;
      end
      if (adv_i) begin
        job_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WIN_LEN-1] <= in_if.sample;
      job_q            <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule
`default_nettype wire

FILE: rtl/swv_var_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swv_var_pipe: variance arithmetic pipeline
// Squares the sum, forms N*sumsq - sum^2 and divides it by N*(N-1) in a
// pipelined restoring divider, a group of quotient digits per stage.
// ----------------------------------------------------------------------------
module swv_var_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               job_valid_i,
  input  swv_pkg::swv_job_t  job_i,
  output logic               work_valid_o,
  output swv_pkg::swv_work_t work_o
);
  import swv_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DIV_BITS-1:0] word;  // dividend shifts out on top, quotient in below
  } div_state_t;

  localparam logic [REM_W:0] DIV_K = (REM_W + 1)'(DIVISOR);

  function automatic div_state_t div_step(div_state_t st);
    logic [REM_W:0] r2;
    logic           qbit;
    div_state_t     res;
    res = st;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      r2   = {res.rem, res.word[DIV_BITS-1]};
      qbit = (r2 >= DIV_K);
      if (qbit) begin
        r2 = r2 - DIV_K;
      end
      res.word = {res.word[DIV_BITS-2:0], qbit};
      res.rem  = r2[REM_W-1:0];
    end
    return res;
  endfunction

  logic [MAG_W-1:0] mag;
  logic [NUM_W-1:0] mag_sq;

  logic             a_valid_q;
  swv_ctl_t         a_ctl_q;
  logic [NUM_W-1:0] a_sq_q, a_ns2_q;

  logic             b_valid_q;
  swv_ctl_t         b_ctl_q;
  logic [NUM_W-1:0] b_num_q;

  logic             d_valid_q [DIV_STAGES];
  swv_ctl_t         d_ctl_q   [DIV_STAGES];
  div_state_t       d_st_q    [DIV_STAGES];
  div_state_t       d_next    [DIV_STAGES];

  assign mag    = job_i.s1[SUM_W-1] ? MAG_W'(-job_i.s1) : MAG_W'(job_i.s1);
  assign mag_sq = mag * mag;

  always_comb begin
    d_next[0] = div_step('{rem: '0, word: DIV_BITS'(b_num_q)});
    for (int k = 1; k < DIV_STAGES; k++) begin
      d_next[k] = div_step(d_st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        d_valid_q[k] <= 1'b0;
      end
    end else if (adv_i) begin
      a_valid_q    <= job_valid_i;
      b_valid_q    <= a_valid_q;
      d_valid_q[0] <= b_valid_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        d_valid_q[k] <= d_valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_ctl_q    <= job_i.ctl;
      a_sq_q     <= mag_sq;
      a_ns2_q    <= NUM_W'(job_i.s2) * NUM_W'(WIN_LEN);
      b_ctl_q    <= a_ctl_q;
      b_num_q    <= a_ns2_q - a_sq_q;
      d_ctl_q[0] <= b_ctl_q;
      d_st_q[0]  <= d_next[0];
      for (int k = 1; k < DIV_STAGES; k++) begin
        d_ctl_q[k] <= d_ctl_q[k-1];
        d_st_q[k]  <= d_next[k];
      end
    end
  end

  assign work_valid_o    = d_valid_q[DIV_STAGES-1];
  assign work_o.ctl      = d_ctl_q[DIV_STAGES-1];
  assign work_o.variance = d_st_q[DIV_STAGES-1].word[VAR_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/swv_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swv_fifo: work queue between the variance pipeline and the back end
// Small register queue of finished jobs; head is shown while not empty.
// ----------------------------------------------------------------------------
module swv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  swv_pkg::swv_work_t data_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output swv_pkg::swv_work_t head_o
);
  import swv_pkg::*;

  swv_work_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;

  assign full_o  = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/swv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swv_back: result expansion and output register
// Turns the queue head into its result words: the centre result if any,
// then the edge zeros of a flush, the last one marked as trace end.
// ----------------------------------------------------------------------------
module swv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  swv_pkg::swv_work_t head_i,
  output logic               pop_o,
  swv_out_if.source          out_if
);
  import swv_pkg::*;

  logic               reg_done_q;
  logic [FLUSH_W-1:0] flush_cnt_q, flush_cnt_inc;
  logic               emit_regular, item_last, load;
  logic               ov_q;
  logic [VAR_W-1:0]   var_q;
  logic               edge_q, end_q;

  assign flush_cnt_inc = flush_cnt_q + 1'b1;
  assign emit_regular  = head_i.ctl.regular && !reg_done_q;
  assign item_last     = emit_regular ? (head_i.ctl.flush_n == '0)
                                      : (flush_cnt_inc == head_i.ctl.flush_n);
  // output slot takes a new word whenever it is empty or being drained
  assign load          = !empty_i && (!ov_q || out_if.ready);
  assign pop_o         = load && item_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_done_q  <= 1'b0;
      flush_cnt_q <= '0;
      ov_q        <= 1'b0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
        if (item_last) begin
          reg_done_q  <= 1'b0;
          flush_cnt_q <= '0;
        end else if (emit_regular) begin
          reg_done_q <= 1'b1;
        end else begin
          flush_cnt_q <= flush_cnt_inc;
        end
      end else if (out_if.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      var_q  <= (emit_regular && head_i.ctl.full) ? head_i.variance : '0;
      edge_q <= emit_regular ? !head_i.ctl.full : 1'b1;
      end_q  <= !emit_regular && item_last;
    end
  end

  assign out_if.valid           = ov_q;
  assign out_if.window_variance = var_q;
  assign out_if.edge_zero       = edge_q;
  assign out_if.trace_end       = end_q;

endmodule
`default_nettype wire

FILE: rtl/sliding_window_variance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_variance: centred moving-window sample variance
// Front end keeps the window sums, a pipeline forms the exact floored
// variance, a short queue decouples it from the result expansion.
// ----------------------------------------------------------------------------
// path: front register, registers a and b, divider stages, queue, output reg
// throughput: one sample per cycle unless stalled; a final sample adds up to
//   HALF_WIDTH+1 words, one per cycle from the output register while ready is high
// the input stalls only when the queue is full and the pipeline end holds a word
// reset: asynchronous, clears sums, sample count, queue and output valid;
//   the sample delay line is not cleared and needs no clearing pass
module sliding_window_variance (
  input  logic      clk_i,
  input  logic      rst_ni,
  swv_in_if.sink    in_if,
  swv_out_if.source out_if
);
  import swv_pkg::*;

  logic      adv;
  logic      job_valid;
  swv_job_t  job;
  logic      work_valid;
  swv_work_t work;
  logic      has_work, push, pop;
  logic      fifo_full, fifo_empty;
  swv_work_t fifo_head;

  // whole front and pipeline move together unless the queue refuses
  assign adv      = !work_valid || !fifo_full;
  assign has_work = work.ctl.regular || (work.ctl.flush_n != '0);
  assign push     = work_valid && adv && has_work;

  swv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .adv_i       (adv),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  swv_var_pipe u_var_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .work_valid_o (work_valid),
    .work_o       (work)
  );

  swv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .head_o  (fifo_head)
  );

  swv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (fifo_empty),
    .head_i  (fifo_head),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire

FILE: rtl/swv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swv_checker: port-level checks for the sliding window variance block
// Watches the result channel: edge words carry zero, the trace end word is
// an edge word, and a stalled word holds.
// ----------------------------------------------------------------------------
module swv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [swv_pkg::VAR_W-1:0] window_variance_i,
  input logic                      edge_zero_i,
  input logic                      trace_end_i
);

  a_end_is_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && trace_end_i |-> edge_zero_i)
    else $error("trace end word not flagged as edge");

  a_edge_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && edge_zero_i |-> window_variance_i == '0)
    else $error("edge word carries a non-zero variance");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({window_variance_i, edge_zero_i, trace_end_i}))
    else $error("stalled result word changed or dropped");

endmodule

bind sliding_window_variance swv_checker u_swv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .window_variance_i (out_if.window_variance),
  .edge_zero_i       (out_if.edge_zero),
  .trace_end_i       (out_if.trace_end)
);
`default_nettype wire

FILE: tb/sliding_window_variance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_variance_checker: result predictor and comparator
// Watches both channels of the block. Every sample word taken in advances a
// private copy of the window, its running sums and the trace length, and
// queues the result words it owes. Every result word taken out is compared,
// field by field, with the oldest owed word. Counts mismatches and the words
// still owed for the test top.
// ----------------------------------------------------------------------------
module sliding_window_variance_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  swv_in_if           in_if,
  swv_out_if          out_if,
  output int unsigned mismatch_count_o,
  output int unsigned words_owed_o
);
  import swv_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic             edge_zero;
    logic             trace_end;
  } variance_word_t;

  variance_word_t             owed_words [$];
  variance_word_t             oldest_owed;
  logic signed [SAMPLE_W-1:0] window_q [WIN_LEN];
  longint                     window_sum;
  u64_t                       window_sq_sum;
  int unsigned                trace_len;
  int unsigned                mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic restart_trace();
    foreach (window_q[i]) window_q[i] = '0;
    window_sum    = 0;
    window_sq_sum = 0;
    trace_len     = 0;
  endtask

  // one sample word in: slide the window, then queue the words it releases
  task automatic take_sample(input logic signed [SAMPLE_W-1:0] x, input logic last);
    longint         oldest;
    longint         mag;
    u64_t           num;
    logic           full;
    int unsigned    flush_n;
    variance_word_t w;
    oldest = longint'(window_q[0]);
    if (trace_len >= WIN_LEN) begin
      window_sum    -= oldest;
      window_sq_sum -= u64_t'(oldest * oldest);
    end
    for (int i = 0; i < WIN_LEN - 1; i++) window_q[i] = window_q[i+1];
    window_q[WIN_LEN-1] = x;
    window_sum    += longint'(x);
    window_sq_sum += u64_t'(longint'(x) * longint'(x));
    if (trace_len < WIN_LEN) trace_len++;

    // centre index of the window becomes known once half a window is in
    if (trace_len >= HALF_WIDTH + 1) begin
      full = (trace_len >= WIN_LEN);
      mag  = (window_sum < 0) ? -window_sum : window_sum;
      num  = u64_t'(WIN_LEN) * window_sq_sum - u64_t'(mag * mag);
      w.variance  = full ? VAR_W'(num / (u64_t'(WIN_LEN) * u64_t'(WIN_LEN - 1))) : '0;
      w.edge_zero = !full;
      w.trace_end = 1'b0;
      owed_words.push_back(w);
    end

    // trailing edge: zeros for the indices still open, last one marks the end
    if (last) begin
      flush_n = (trace_len < HALF_WIDTH) ? trace_len : HALF_WIDTH;
      for (int unsigned f = 0; f < flush_n; f++) begin
        w.variance  = '0;
        w.edge_zero = 1'b1;
        w.trace_end = (f + 1 == flush_n);
        owed_words.push_back(w);
      end
      restart_trace();
    end
  endtask

  // results are compared before the new sample is taken: a word leaving at
  // this edge can never belong to the sample entering at it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_words.delete();
      restart_trace();
      words_owed_o <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("result word with none owed, variance %0d edge %0b end %0b",
                                    out_if.window_variance, out_if.edge_zero,
                                    out_if.trace_end));
        end else begin
          oldest_owed = owed_words.pop_front();
          if (out_if.window_variance !== oldest_owed.variance) begin
            report_mismatch($sformatf("window_variance expected %0d, got %0d",
                                      oldest_owed.variance, out_if.window_variance));
          end
          if (out_if.edge_zero !== oldest_owed.edge_zero) begin
            report_mismatch($sformatf("edge_zero expected %0b, got %0b",
                                      oldest_owed.edge_zero, out_if.edge_zero));
          end
          if (out_if.trace_end !== oldest_owed.trace_end) begin
            report_mismatch($sformatf("trace_end expected %0b, got %0b",
                                      oldest_owed.trace_end, out_if.trace_end));
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        take_sample(in_if.sample, in_if.final_sample);
      end
      words_owed_o <= owed_words.size();
    end
  end

endmodule

FILE: tb/sliding_window_variance_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_variance_test: stimulus and verdict for the variance block
// Feeds traces of signed samples: a few short directed traces at the sample
// extremes, then random traces of many lengths and shapes, with random gaps
// on both channels, a long output hold that backs the block up and a pause
// until all owed words are out. The checker beside the block does the
// comparing; this top only drives and gives the verdict.
// ----------------------------------------------------------------------------
module sliding_window_variance_test;
  import swv_pkg::*;

  localparam int unsigned SAMPLE_TARGET = 300;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AT_WORD  = 60;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned MAX_GAP       = 15;

  typedef enum logic [1:0] {
    SHAPE_RANDOM,
    SHAPE_EXTREME,
    SHAPE_FLAT,
    SHAPE_NOISY
  } trace_shape_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        sample_taken = 1'b0;
  logic        word_taken   = 1'b0;
  logic        long_hold    = 1'b0;
  int unsigned samples_sent = 0;
  int unsigned words_seen   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned mismatches;
  int unsigned words_owed;

  swv_in_if  in_ch ();
  swv_out_if out_ch ();

  sliding_window_variance dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  sliding_window_variance_checker variance_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_if            (in_ch),
    .out_if           (out_ch),
    .mismatch_count_o (mismatches),
    .words_owed_o     (words_owed)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // handshakes seen at the rising edge, read back at the next falling edge
  always @(posedge clk_i) begin
    sample_taken <= in_ch.valid && in_ch.ready;
    word_taken   <= out_ch.valid && out_ch.ready;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL sliding_window_variance");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] trace_value(
    input trace_shape_e               shape,
    input logic signed [SAMPLE_W-1:0] base
  );
    case (shape)
      SHAPE_RANDOM:  return SAMPLE_W'($urandom);
      SHAPE_EXTREME: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      SHAPE_FLAT:    return base;
      default:       return base + SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
    endcase
  endfunction

  // entered and left at a falling edge; valid stays up after the word is taken
  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int unsigned gap;
    if (samples_sent == SAMPLE_TARGET / 2) begin
      // hold the input until every owed word has come out
      in_ch.valid = 1'b0;
      @(negedge clk_i);
      while (words_owed != 0) @(negedge clk_i);
    end
    gap = (long_hold || (samples_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        = 1'b1;
    in_ch.sample       = s;
    in_ch.final_sample = last;
    @(negedge clk_i);
    while (!sample_taken) @(negedge clk_i);
    samples_sent++;
  endtask

  task automatic send_trace(input int unsigned len, input trace_shape_e shape);
    logic signed [SAMPLE_W-1:0] base;
    base = SAMPLE_W'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(trace_value(shape, base), i + 1 == len);
    end
  endtask

  initial begin
    int unsigned                len;
    int unsigned                boundary_lens [6];
    logic signed [SAMPLE_W-1:0] corner_vals [4];
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.final_sample = 1'b0;
    boundary_lens = '{HALF_WIDTH, HALF_WIDTH + 1, HALF_WIDTH + 2,
                      WIN_LEN - 1, WIN_LEN, WIN_LEN + 1};
    corner_vals   = '{16'sh7fff, 16'sh8000, 16'shffff, 16'sh0000};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // one-sample trace, two-sample trace, then a trace one half window long
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b1);
    for (int unsigned i = 0; i < HALF_WIDTH; i++) begin
      send_word(corner_vals[i % 4], i + 1 == HALF_WIDTH);
    end

    while (samples_sent < SAMPLE_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, 2 * HALF_WIDTH);
        2:       len = boundary_lens[$urandom_range(0, 5)];
        3:       len = $urandom_range(100, 160);
        default: len = $urandom_range(WIN_LEN, 80);
      endcase
      // last trace is cut short so the run stays near the sample target
      if (len > SAMPLE_TARGET - samples_sent) begin
        len = SAMPLE_TARGET - samples_sent;
      end
      send_trace(len, trace_shape_e'($urandom_range(0, 3)));
    end
    in_ch.valid = 1'b0;

    while (words_owed != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && words_owed == 0) begin
      $display("PASS sliding_window_variance");
    end else begin
      $display("FAIL sliding_window_variance");
    end
    $finish;
  end

  // result side: random stalls, stall-free stretches and one long hold
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (words_seen == HOLD_AT_WORD && !long_hold) begin
        long_hold    = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold    = 1'b0;
        words_seen++;
      end
      gap = ((words_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
        out_ch.ready = 1'b0;
        @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      @(negedge clk_i);
      while (!word_taken) @(negedge clk_i);
      words_seen++;
    end
  end

endmodule
